/* src/cda_pkg.sv */
// cda_pkg: shared types, codes and calendar constants for the date stepper
// used by cda_cal_unit and calendar_date_advance; depends on nothing

package cda_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 12;
  localparam int OP_W    = 2;

  localparam int MAX_DAY_COUNT_DEF = 4095;

  localparam logic [YEAR_W-1:0]  LAST_YEAR = 14'd9999;
  localparam logic [MONTH_W-1:0] DECEMBER  = 4'd12;
  localparam logic [MONTH_W-1:0] FEBRUARY  = 4'd2;
  localparam logic [DAY_W-1:0]   FEB_LEAP  = 5'd29;
  localparam logic [DAY_W-1:0]   FEB_PLAIN = 5'd28;

  // divisibility by 25: y * inv(25) mod 2^14 falls at or below 16383/25
  localparam logic [YEAR_W-1:0] INV25       = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_LIMIT = 14'd655;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD_DAY   = 2'd0,
    OP_ADD_MONTH = 2'd1,
    OP_ADD_N     = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DAYS,
    ST_MONTH,
    ST_CLAMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  // results of the shared step unit for the current date
  typedef struct packed {
    logic [DAY_W-1:0] len;
    date_t            day_next;
    logic             day_wrap;
    date_t            month_next;
    logic             month_wrap;
  } step_t;

  // month length for a common year, zero for a month that does not exist
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

/* src/calendar_date_advance.sv */
// calendar_date_advance: Gregorian date stepper, top level and sequencer
// depends on cda_pkg and cda_cal_unit
// after accept the sequencer checks the date and goes straight to the strobe for
// an invalid date, op 3 or a zero count; add-day and add-N (N saturated) step the
// date in the shared calendar unit one day per cycle; add-month steps the month
// and then clamps the day; busy stays high through the strobe cycle
// synchronous active-low reset returns the sequencer to idle, no result pending

module calendar_date_advance #(
  parameter int MAX_DAY_COUNT = cda_pkg::MAX_DAY_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [cda_pkg::OP_W-1:0]     in_op,
  input  logic [cda_pkg::DAY_W-1:0]    in_day_in,
  input  logic [cda_pkg::MONTH_W-1:0]  in_month_in,
  input  logic [cda_pkg::YEAR_W-1:0]   in_year_in,
  input  logic [cda_pkg::COUNT_W-1:0]  in_day_count,
  output logic                         out_valid,
  output logic [cda_pkg::DAY_W-1:0]    out_day_out,
  output logic [cda_pkg::MONTH_W-1:0]  out_month_out,
  output logic [cda_pkg::YEAR_W-1:0]   out_year_out,
  output logic                         out_year_overflow,
  output logic                         out_date_invalid
);

  localparam int CW = $clog2(MAX_DAY_COUNT + 1);
  localparam int SW = (CW > cda_pkg::COUNT_W) ? CW : cda_pkg::COUNT_W;

  cda_pkg::state_t state_r, state_nxt;
  cda_pkg::op_t    op_r, op_nxt;
  cda_pkg::date_t  date_r, date_nxt;
  cda_pkg::step_t  step;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            wrap_r, wrap_nxt;
  logic            inv_r, inv_nxt;
  logic [SW-1:0]   cnt_sat;
  logic            accept;
  logic            invalid;

  cda_cal_unit u_cal (
    .cur  (date_r),
    .step (step)
  );

  assign accept = start && !busy;

  // day count saturated to the configured maximum
  assign cnt_sat = (SW'(in_day_count) > SW'(MAX_DAY_COUNT)) ? SW'(MAX_DAY_COUNT)
                                                            : SW'(in_day_count);

  // impossible input date check on the loaded date
  assign invalid = (date_r.day == '0) || (date_r.month == '0) ||
                   (date_r.month > cda_pkg::DECEMBER) ||
                   (date_r.year > cda_pkg::LAST_YEAR) || (date_r.day > step.len);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cda_pkg::ST_IDLE: begin
        if (accept) state_nxt = cda_pkg::ST_CHECK;
      end
      cda_pkg::ST_CHECK: begin
        if (invalid) begin
          state_nxt = cda_pkg::ST_DONE;
        end else begin
          case (op_r)
            cda_pkg::OP_ADD_DAY:   state_nxt = cda_pkg::ST_DAYS;
            cda_pkg::OP_ADD_MONTH: state_nxt = cda_pkg::ST_MONTH;
            cda_pkg::OP_ADD_N:     state_nxt = (cnt_r == '0) ? cda_pkg::ST_DONE
                                                             : cda_pkg::ST_DAYS;
            default:               state_nxt = cda_pkg::ST_DONE;
          endcase
        end
      end
      cda_pkg::ST_DAYS: begin
        if (cnt_r == CW'(1)) state_nxt = cda_pkg::ST_DONE;
      end
      cda_pkg::ST_MONTH: state_nxt = cda_pkg::ST_CLAMP;
      cda_pkg::ST_CLAMP: state_nxt = cda_pkg::ST_DONE;
      cda_pkg::ST_DONE:  state_nxt = cda_pkg::ST_IDLE;
      default:           state_nxt = cda_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      cda_pkg::ST_IDLE: busy      = 1'b0;
      cda_pkg::ST_DONE: out_valid = 1'b1;
      default:          busy      = 1'b1;
    endcase
  end

  // datapath next values
  always_comb begin
    op_nxt   = op_r;
    date_nxt = date_r;
    cnt_nxt  = cnt_r;
    wrap_nxt = wrap_r;
    inv_nxt  = inv_r;
    case (state_r)
      cda_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt   = cda_pkg::op_t'(in_op);
          date_nxt = '{day: in_day_in, month: in_month_in, year: in_year_in};
          cnt_nxt  = CW'(cnt_sat);
          wrap_nxt = 1'b0;
          inv_nxt  = 1'b0;
        end
      end
      cda_pkg::ST_CHECK: begin
        inv_nxt = invalid;
        if (op_r == cda_pkg::OP_ADD_DAY) cnt_nxt = CW'(1);
      end
      cda_pkg::ST_DAYS: begin
        date_nxt = step.day_next;
        wrap_nxt = wrap_r | step.day_wrap;
        cnt_nxt  = cnt_r - 1'b1;
      end
      cda_pkg::ST_MONTH: begin
        date_nxt = step.month_next;
        wrap_nxt = wrap_r | step.month_wrap;
      end
      cda_pkg::ST_CLAMP: begin
        if (date_r.day > step.len) date_nxt.day = step.len;
      end
      default: begin
        date_nxt = date_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cda_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    date_r <= date_nxt;
    cnt_r  <= cnt_nxt;
    wrap_r <= wrap_nxt;
    inv_r  <= inv_nxt;
  end

  // result ports
  assign out_day_out       = date_r.day;
  assign out_month_out     = date_r.month;
  assign out_year_out      = date_r.year;
  assign out_year_overflow = wrap_r;
  assign out_date_invalid  = inv_r;

  // strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy && !out_valid)
    else $error("accepted transaction did not start the sequencer");

  // an invalid date never reports a year wrap
  a_invalid_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_date_invalid) |-> !out_year_overflow)
    else $error("invalid date reported a year wrap");

  // a valid result holds a real month and a nonzero day
  a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_date_invalid) |->
      (out_month_out != '0) && (out_month_out <= cda_pkg::DECEMBER) &&
      (out_day_out != '0))
    else $error("valid result holds an impossible date");

  // day stepping never runs with an exhausted count
  a_days_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cda_pkg::ST_DAYS) |-> (cnt_r != '0))
    else $error("day stepping with zero remaining count");

endmodule

/* src/cda_cal_unit.sv */
// cda_cal_unit: shared calendar unit, month length with leap rule plus
// one-day and one-month steps of the current date; depends on cda_pkg

module cda_cal_unit (
  input  cda_pkg::date_t cur,
  output cda_pkg::step_t step
);

  logic [2*cda_pkg::YEAR_W-1:0] prod;
  logic [cda_pkg::YEAR_W-1:0]   yr_next;
  logic                         yr_wrap;
  logic                         div4;
  logic                         div16;
  logic                         div25;
  logic                         leap;
  logic [cda_pkg::DAY_W-1:0]    cur_len;
  cda_pkg::date_t               day_next;
  logic                         day_wrap;
  cda_pkg::date_t               month_next;
  logic                         month_wrap;

  // leap year by the 4/100/400 rule, divisibility by 25 via modular inverse
  always_comb begin
    prod  = (2*cda_pkg::YEAR_W)'(cur.year) * (2*cda_pkg::YEAR_W)'(cda_pkg::INV25);
    div25 = (prod[cda_pkg::YEAR_W-1:0] <= cda_pkg::DIV25_LIMIT);
    div4  = (cur.year[1:0] == 2'd0);
    div16 = (cur.year[3:0] == 4'd0);
    leap  = (div4 && !div25) || (div16 && div25);
  end

  // month length of the current date
  always_comb begin
    if (cur.month == cda_pkg::FEBRUARY) begin
      cur_len = leap ? cda_pkg::FEB_LEAP : cda_pkg::FEB_PLAIN;
    end else begin
      cur_len = cda_pkg::month_len(cur.month);
    end
  end

  // year increment with wrap past the last year
  always_comb begin
    if (cur.year >= cda_pkg::LAST_YEAR) begin
      yr_next = '0;
      yr_wrap = 1'b1;
    end else begin
      yr_next = cur.year + 1'b1;
      yr_wrap = 1'b0;
    end
  end

  // one day forward
  always_comb begin
    day_next = cur;
    day_wrap = 1'b0;
    if (cur.day >= cur_len) begin
      day_next.day = 5'd1;
      if (cur.month >= cda_pkg::DECEMBER) begin
        day_next.month = 4'd1;
        day_next.year  = yr_next;
        day_wrap       = yr_wrap;
      end else begin
        day_next.month = cur.month + 1'b1;
      end
    end else begin
      day_next.day = cur.day + 1'b1;
    end
  end

  // one month forward, day clamp happens on the following cycle
  always_comb begin
    month_next = cur;
    month_wrap = 1'b0;
    if (cur.month >= cda_pkg::DECEMBER) begin
      month_next.month = 4'd1;
      month_next.year  = yr_next;
      month_wrap       = yr_wrap;
    end else begin
      month_next.month = cur.month + 1'b1;
    end
  end

  // collected step results
  assign step = '{len: cur_len, day_next: day_next, day_wrap: day_wrap,
                  month_next: month_next, month_wrap: month_wrap};

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for calendar_date_advance (day, month and n-day steps)
// depends on cda_pkg and calendar_date_advance; predicts every result in-bench

module testbench;

  // one predicted or observed result
  typedef struct packed {
    logic [cda_pkg::DAY_W-1:0]   day;
    logic [cda_pkg::MONTH_W-1:0] month;
    logic [cda_pkg::YEAR_W-1:0]  year;
    logic                        overflow;
    logic                        invalid;
  } date_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [cda_pkg::OP_W-1:0]    in_op = '0;
  logic [cda_pkg::DAY_W-1:0]   in_day_in = '0;
  logic [cda_pkg::MONTH_W-1:0] in_month_in = '0;
  logic [cda_pkg::YEAR_W-1:0]  in_year_in = '0;
  logic [cda_pkg::COUNT_W-1:0] in_day_count = '0;
  logic                        out_valid;
  logic [cda_pkg::DAY_W-1:0]   out_day_out;
  logic [cda_pkg::MONTH_W-1:0] out_month_out;
  logic [cda_pkg::YEAR_W-1:0]  out_year_out;
  logic                        out_year_overflow;
  logic                        out_date_invalid;

  date_result_t pending_dates[$];
  int           mismatches = 0;
  bit           gaps_on = 1'b1;

  calendar_date_advance DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_day_in         (in_day_in),
    .in_month_in       (in_month_in),
    .in_year_in        (in_year_in),
    .in_day_count      (in_day_count),
    .out_valid         (out_valid),
    .out_day_out       (out_day_out),
    .out_month_out     (out_month_out),
    .out_year_out      (out_year_out),
    .out_year_overflow (out_year_overflow),
    .out_date_invalid  (out_date_invalid)
  );

  // clock
  always #5 clk = ~clk;

  // gregorian leap rule
  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // month length, zero for a month that does not exist
  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    if (m < 1 || m > 12) return 0;
    if (m == 2) return is_leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  // expected result of one transaction
  function automatic date_result_t advance_date(input cda_pkg::op_t op,
                                                input logic [cda_pkg::DAY_W-1:0] d_in,
                                                input logic [cda_pkg::MONTH_W-1:0] m_in,
                                                input logic [cda_pkg::YEAR_W-1:0] y_in,
                                                input logic [cda_pkg::COUNT_W-1:0] n_in);
    int unsigned d, m, y, n, len;
    bit wrap, bad;
    date_result_t r;
    d = d_in;
    m = m_in;
    y = y_in;
    n = 0;
    wrap = 1'b0;
    bad = (d == 0) || (m < 1) || (m > 12) || (y > 9999) || (d > month_days(m, y));
    if (!bad) begin
      if (op == cda_pkg::OP_ADD_DAY) n = 1;
      if (op == cda_pkg::OP_ADD_N)
        n = (n_in > cda_pkg::MAX_DAY_COUNT_DEF) ? cda_pkg::MAX_DAY_COUNT_DEF : n_in;
      // day steps
      for (int unsigned i = 0; i < n; i++) begin
        if (d >= month_days(m, y)) begin
          d = 1;
          if (m >= 12) begin
            m = 1;
            if (y >= 9999) begin
              y = 0;
              wrap = 1'b1;
            end else begin
              y = y + 1;
            end
          end else begin
            m = m + 1;
          end
        end else begin
          d = d + 1;
        end
      end
      // month step with clamp
      if (op == cda_pkg::OP_ADD_MONTH) begin
        if (m >= 12) begin
          m = 1;
          if (y >= 9999) begin
            y = 0;
            wrap = 1'b1;
          end else begin
            y = y + 1;
          end
        end else begin
          m = m + 1;
        end
        len = month_days(m, y);
        if (d > len) d = len;
      end
    end
    r.day = cda_pkg::DAY_W'(d);
    r.month = cda_pkg::MONTH_W'(m);
    r.year = cda_pkg::YEAR_W'(y);
    r.overflow = wrap;
    r.invalid = bad;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ERROR: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // drive one transaction and wait until it is accepted
  task automatic send_date(input cda_pkg::op_t op, input logic [cda_pkg::DAY_W-1:0] d,
                           input logic [cda_pkg::MONTH_W-1:0] m,
                           input logic [cda_pkg::YEAR_W-1:0] y,
                           input logic [cda_pkg::COUNT_W-1:0] n);
    if (gaps_on && $urandom_range(0, 99) < 33) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start        <= 1'b1;
    in_op        <= op;
    in_day_in    <= d;
    in_month_in  <= m;
    in_year_in   <= y;
    in_day_count <= n;
    do @(posedge clk); while (!(start && !busy));
    pending_dates.push_back(advance_date(op, d, m, y, n));
  endtask

  // compare each result against the oldest pending transaction
  always @(posedge clk) begin : check_results
    date_result_t want;
    if (rst_n && out_valid) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("result with no transaction pending");
      end else begin
        want = pending_dates.pop_front();
        check_field("day", int'(out_day_out), int'(want.day));
        check_field("month", int'(out_month_out), int'(want.month));
        check_field("year", int'(out_year_out), int'(want.year));
        check_field("year_overflow", int'(out_year_overflow), int'(want.overflow));
        check_field("date_invalid", int'(out_date_invalid), int'(want.invalid));
      end
    end
  end

  // month ends, leap days and the year wrap
  task automatic test_add_day();
    send_date(cda_pkg::OP_ADD_DAY, 31, 1, 2023, 0);
    send_date(cda_pkg::OP_ADD_DAY, 28, 2, 2023, 0);
    send_date(cda_pkg::OP_ADD_DAY, 28, 2, 2024, 0);
    send_date(cda_pkg::OP_ADD_DAY, 29, 2, 2000, 0);
    send_date(cda_pkg::OP_ADD_DAY, 28, 2, 1900, 0);
    send_date(cda_pkg::OP_ADD_DAY, 28, 2, 0, 4095);
    send_date(cda_pkg::OP_ADD_DAY, 31, 12, 9999, 0);
  endtask

  // clamp to the new month and december rollover
  task automatic test_add_month();
    send_date(cda_pkg::OP_ADD_MONTH, 31, 1, 2024, 0);
    send_date(cda_pkg::OP_ADD_MONTH, 31, 1, 2100, 0);
    send_date(cda_pkg::OP_ADD_MONTH, 31, 3, 2023, 0);
    send_date(cda_pkg::OP_ADD_MONTH, 15, 12, 9999, 0);
    send_date(cda_pkg::OP_ADD_MONTH, 31, 12, 1999, 0);
  endtask

  // zero, one and full-range day counts
  task automatic test_add_days();
    send_date(cda_pkg::OP_ADD_N, 15, 6, 2020, 0);
    send_date(cda_pkg::OP_ADD_N, 31, 12, 2022, 1);
    send_date(cda_pkg::OP_ADD_N, 1, 1, 9995, 4095);
    send_date(cda_pkg::OP_ADD_N, 29, 2, 2000, 4095);
    send_date(cda_pkg::OP_ADD_N, 1, 3, 1999, 366);
  endtask

  // impossible dates and the unused op code
  task automatic test_invalid_dates();
    send_date(cda_pkg::OP_ADD_DAY, 0, 5, 2020, 0);
    send_date(cda_pkg::OP_ADD_MONTH, 10, 0, 2020, 0);
    send_date(cda_pkg::OP_ADD_N, 31, 15, 16383, 4095);
    send_date(cda_pkg::OP_ADD_DAY, 30, 2, 2024, 0);
    send_date(cda_pkg::OP_ADD_MONTH, 31, 4, 2023, 0);
    send_date(cda_pkg::OP_ADD_N, 29, 2, 1900, 10);
    send_date(cda_pkg::OP_NONE, 31, 12, 9999, 100);
    send_date(cda_pkg::OP_NONE, 0, 0, 0, 0);
  endtask

  // mostly valid dates biased to month ends, centuries and the last years
  task automatic test_random_dates(input int count, input bit allow_gaps);
    int unsigned roll, d, m, y, n, len;
    cda_pkg::op_t op;
    gaps_on = allow_gaps;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) op = cda_pkg::OP_ADD_DAY;
      else if (roll < 55) op = cda_pkg::OP_ADD_MONTH;
      else if (roll < 95) op = cda_pkg::OP_ADD_N;
      else op = cda_pkg::OP_NONE;
      n = $urandom_range(0, 4095);
      if (op == cda_pkg::OP_ADD_N) begin
        roll = $urandom_range(0, 99);
        if (roll < 80) n = $urandom_range(0, 60);
        else if (roll < 97) n = $urandom_range(61, 800);
        else n = $urandom_range(3000, 4095);
      end
      if ($urandom_range(0, 99) < 15) begin
        // noise: any field value
        d = $urandom_range(0, 31);
        m = $urandom_range(0, 15);
        y = $urandom_range(0, 16383);
      end else begin
        m = $urandom_range(1, 12);
        roll = $urandom_range(0, 99);
        if (roll < 20) y = $urandom_range(9990, 9999);
        else if (roll < 30) y = $urandom_range(0, 99) * 100;
        else y = $urandom_range(0, 9999);
        len = month_days(m, y);
        if ($urandom_range(0, 99) < 30) d = $urandom_range(len - 1, len);
        else d = $urandom_range(1, len);
      end
      send_date(op, cda_pkg::DAY_W'(d), cda_pkg::MONTH_W'(m), cda_pkg::YEAR_W'(y),
                cda_pkg::COUNT_W'(n));
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_add_day();
    test_add_month();
    test_add_days();
    test_invalid_dates();
    test_random_dates(75, 1'b1);
    test_random_dates(40, 1'b0);
    start <= 1'b0;
    // drain outstanding results
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* calendar_date_advance.f */
src/cda_pkg.sv
src/cda_cal_unit.sv
src/calendar_date_advance.sv
dv/testbench.sv
